// File: sv/assert_macros.svh
// assertion macros shared by the symbol lookup modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/spl_pkg.sv
// shared types and constants for the symbol predecessor lookup
package spl_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = 64;
    localparam int NAME_W      = 32;
    localparam int FLAG_W      = 32;
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QFILL_W     = $clog2(QDEPTH + 1);

    localparam logic [DATA_W-1:0] VALID_MAGIC = 32'h5359_4D53;

    typedef enum logic [0:0] {
        REQ_STORE  = 1'b0,
        REQ_LOOKUP = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        STAT_FOUND  = 2'd0,
        STAT_MISS   = 2'd1,
        STAT_STORED = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC      = 2'd0,
        CFG_COUNT      = 2'd1,
        CFG_NAMES_SIZE = 2'd2
    } t_cfg_idx;

    // what the front decided an item is
    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_DROP,
        KIND_MISS,
        KIND_LOOKUP
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [NAME_W-1:0] name_pos;
        logic [FLAG_W-1:0] flags;
        logic              has_name;
    } t_entry;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  slot;
        t_entry            entry;
        logic [ADDR_W-1:0] query;
        logic [CNT_W-1:0]  count;
    } t_q_item;

endpackage

// File: sv/spl_front.sv
// front end: accepts items, classifies them and queues them for the search engine
module spl_front
    import spl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_req_type,
    input  logic [IDX_W-1:0]  i_entry_slot,
    input  logic [ADDR_W-1:0] i_entry_start,
    input  logic [NAME_W-1:0] i_entry_name_pos,
    input  logic [FLAG_W-1:0] i_entry_flag_bits,
    input  logic              i_entry_has_name,
    input  logic [ADDR_W-1:0] i_query_address,
    input  logic [DATA_W-1:0] i_table_magic,
    input  logic [CNT_W-1:0]  i_entry_count,
    output logic              o_head_valid,
    output t_q_item           o_head,
    input  logic              i_pop
);

`include "assert_macros.svh"

    t_q_item             r_q [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QFILL_W-1:0]  r_fill;
    logic [QFILL_W-1:0]  n_fill;
    logic                w_push;
    logic                w_pop;
    logic [CNT_W-1:0]    w_count_sat;
    t_q_item             w_item;

    assign o_ready      = (r_fill != QFILL_W'(QDEPTH));
    assign o_head_valid = (r_fill != '0);
    assign o_head       = r_q[r_rd_ptr];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_pop && o_head_valid;

    always_comb begin
        w_count_sat = (i_entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                            : i_entry_count;
        w_item.slot           = i_entry_slot;
        w_item.entry.start    = i_entry_start;
        w_item.entry.name_pos = i_entry_name_pos;
        w_item.entry.flags    = i_entry_flag_bits;
        w_item.entry.has_name = i_entry_has_name;
        w_item.query          = i_query_address;
        w_item.count          = w_count_sat;
        if (t_req'(i_req_type) == REQ_STORE) begin
            w_item.kind = (CNT_W'(i_entry_slot) >= CNT_W'(MAX_ENTRIES)) ? KIND_DROP
                                                                       : KIND_STORE;
        end else if ((i_table_magic != VALID_MAGIC) || (w_count_sat == '0)) begin
            w_item.kind = KIND_MISS;
        end else begin
            w_item.kind = KIND_LOOKUP;
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    `ASSERT_NEXT(a_fill_up, i_clk, i_rst_n, w_push && !w_pop,
        r_fill == $past(r_fill) + 1'b1, "queue fill did not grow on push")
    `ASSERT_IMPLIES(a_ptr_gap, i_clk, i_rst_n, r_fill == '0 || r_fill == QFILL_W'(QDEPTH),
        r_wr_ptr == r_rd_ptr, "queue pointers disagree with fill count")

endmodule

// File: sv/spl_back.sv
// back end: symbol table memory, binary search engine and result register
module spl_back
    import spl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  t_q_item           i_head,
    output logic              o_pop,
    input  logic [NAME_W-1:0] i_names_size,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [ADDR_W-1:0] o_symbol_start,
    output logic [ADDR_W-1:0] o_offset_in_symbol,
    output logic [NAME_W-1:0] o_name_pos,
    output logic [FLAG_W-1:0] o_symbol_flags
);

`include "assert_macros.svh"

    t_entry              r_mem [MAX_ENTRIES];
    t_entry              r_rd_data;
    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi;
    logic [CNT_W-1:0]    r_mid;
    logic [ADDR_W-1:0]   r_query;
    t_status             r_res_status;
    logic [ADDR_W-1:0]   r_res_start;
    logic [ADDR_W-1:0]   r_res_offset;
    logic [NAME_W-1:0]   r_res_name;
    logic [FLAG_W-1:0]   r_res_flags;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [ADDR_W-1:0]   r_out_start;
    logic [ADDR_W-1:0]   r_out_offset;
    logic [NAME_W-1:0]   r_out_name;
    logic [FLAG_W-1:0]   r_out_flags;

    logic                w_le;
    logic [CNT_W-1:0]    w_lo_nx;
    logic [CNT_W-1:0]    w_hi_nx;
    logic [CNT_W-1:0]    w_mid_nx;
    logic                w_more;
    logic [CNT_W-1:0]    w_next_mid;
    logic [CNT_W-1:0]    w_rd_sel;
    logic                w_mem_we;
    logic                w_out_free;
    logic                w_out_load;
    logic                w_name_ok;

    // one probe step: compare the entry just read and narrow the window
    always_comb begin
        w_le       = (r_rd_data.start <= r_query);
        w_lo_nx    = w_le ? (r_mid + 1'b1) : r_lo;
        w_hi_nx    = w_le ? r_hi : r_mid;
        w_mid_nx   = w_lo_nx + ((w_hi_nx - w_lo_nx) >> 1);
        w_more     = (w_lo_nx < w_hi_nx);
        // once the window closes, fetch the predecessor entry
        w_next_mid = w_more ? w_mid_nx : (w_lo_nx - 1'b1);
        w_out_free = !r_out_valid || i_ready;
        w_name_ok  = (r_rd_data.name_pos < i_names_size) && r_rd_data.has_name;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    n_state = (i_head.kind == KIND_LOOKUP) ? ST_PROBE : ST_RESULT;
                end
            end
            ST_PROBE: begin
                if (!w_more) begin
                    n_state = (w_lo_nx == '0) ? ST_RESULT : ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        w_mem_we   = 1'b0;
        w_out_load = 1'b0;
        w_rd_sel   = w_next_mid;
        unique case (r_state)
            ST_IDLE: begin
                o_pop    = i_head_valid;
                w_mem_we = i_head_valid && (i_head.kind == KIND_STORE);
                w_rd_sel = i_head.count >> 1;
            end
            ST_PROBE: begin
                w_rd_sel = w_next_mid;
            end
            ST_CHECK: begin
                w_rd_sel = r_mid;
            end
            ST_RESULT: begin
                w_out_load = w_out_free;
                w_rd_sel   = r_mid;
            end
            default: begin
                w_rd_sel = r_mid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[i_head.slot] <= i_head.entry;
        end
        r_rd_data <= r_mem[w_rd_sel[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    r_lo         <= '0;
                    r_hi         <= i_head.count;
                    r_mid        <= i_head.count >> 1;
                    r_query      <= i_head.query;
                    r_res_start  <= '0;
                    r_res_offset <= '0;
                    r_res_name   <= '0;
                    r_res_flags  <= '0;
                    r_res_status <= (i_head.kind == KIND_STORE) ? STAT_STORED : STAT_MISS;
                end
            end
            ST_PROBE: begin
                r_lo  <= w_lo_nx;
                r_hi  <= w_hi_nx;
                r_mid <= w_next_mid;
            end
            ST_CHECK: begin
                if (w_name_ok) begin
                    r_res_status <= STAT_FOUND;
                    r_res_start  <= r_rd_data.start;
                    r_res_offset <= r_query - r_rd_data.start;
                    r_res_name   <= r_rd_data.name_pos;
                    r_res_flags  <= r_rd_data.flags;
                end
            end
            ST_RESULT: begin
                if (w_out_load) begin
                    r_out_status <= r_res_status;
                    r_out_start  <= r_res_start;
                    r_out_offset <= r_res_offset;
                    r_out_name   <= r_res_name;
                    r_out_flags  <= r_res_flags;
                end
            end
            default: begin
                r_lo <= r_lo;
            end
        endcase
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_symbol_start     = r_out_start;
    assign o_offset_in_symbol = r_out_offset;
    assign o_name_pos         = r_out_name;
    assign o_symbol_flags     = r_out_flags;

    `ASSERT_IMPLIES(a_mid_in_window, i_clk, i_rst_n, r_state == ST_PROBE,
        r_mid >= r_lo && r_mid < r_hi, "probe index outside search window")
    `ASSERT_IMPLIES(a_check_has_pred, i_clk, i_rst_n, r_state == ST_CHECK,
        r_lo != '0 && r_mid == r_lo - 1'b1, "predecessor check without a candidate")

endmodule

// File: sv/symbol_predecessor_lookup_core.sv
// top level of the symbol predecessor lookup: configuration registers and the two halves
// A symbol table of up to 1024 entries, kept sorted by start address by software, sits in a
// memory with one write port and one registered read port. A store word leaves the queue and
// writes its entry in ST_IDLE; ST_RESULT then stages its status 2 result, which moves into the
// output register once that register is free, and the sink sees it from there. A lookup word
// binary-searches the first entry_count entries. Each probe uses the table memory's read port,
// and a lookup needs at most ceil(log2(count+1)) probes. A check step (ST_CHECK) then reads the
// predecessor entry and checks its name; it is skipped when no entry is at or below the query.
// Queue hand-off (ST_IDLE) comes before the probes and result staging (ST_RESULT) after them.
// A lookup that the front already knows will miss (wrong magic, zero count) goes from ST_IDLE
// straight to ST_RESULT, as a store does. Items are taken one at a time by the search
// engine; a two-word queue in front lets the next word be accepted while the current one is
// searched, and a result register lets a finished result wait for the sink.
// The configuration port is always ready and must only be written while the block is idle.
module symbol_predecessor_lookup_core
    import spl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic [IDX_W-1:0]     i_entry_slot,
    input  logic [ADDR_W-1:0]    i_entry_start,
    input  logic [NAME_W-1:0]    i_entry_name_pos,
    input  logic [FLAG_W-1:0]    i_entry_flag_bits,
    input  logic                 i_entry_has_name,
    input  logic [ADDR_W-1:0]    i_query_address,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [ADDR_W-1:0]    o_symbol_start,
    output logic [ADDR_W-1:0]    o_offset_in_symbol,
    output logic [NAME_W-1:0]    o_name_pos,
    output logic [FLAG_W-1:0]    o_symbol_flags
);

    logic [DATA_W-1:0] r_magic;
    logic [CNT_W-1:0]  r_count;
    logic [NAME_W-1:0] r_names_size;
    logic              w_head_valid;
    t_q_item           w_head;
    logic              w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic      <= '0;
            r_count      <= '0;
            r_names_size <= NAME_W'(1);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAGIC:      r_magic      <= i_cfg_data;
                CFG_COUNT:      r_count      <= i_cfg_data[CNT_W-1:0];
                CFG_NAMES_SIZE: r_names_size <= i_cfg_data[NAME_W-1:0];
                default: begin
                    r_magic <= r_magic;
                end
            endcase
        end
    end

    spl_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_req_type        (i_req_type),
        .i_entry_slot      (i_entry_slot),
        .i_entry_start     (i_entry_start),
        .i_entry_name_pos  (i_entry_name_pos),
        .i_entry_flag_bits (i_entry_flag_bits),
        .i_entry_has_name  (i_entry_has_name),
        .i_query_address   (i_query_address),
        .i_table_magic     (r_magic),
        .i_entry_count     (r_count),
        .o_head_valid      (w_head_valid),
        .o_head            (w_head),
        .i_pop             (w_pop)
    );

    spl_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head_valid       (w_head_valid),
        .i_head             (w_head),
        .o_pop              (w_pop),
        .i_names_size       (r_names_size),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_symbol_start     (o_symbol_start),
        .o_offset_in_symbol (o_offset_in_symbol),
        .o_name_pos         (o_name_pos),
        .o_symbol_flags     (o_symbol_flags)
    );

endmodule
